>>> sv/macd_divergence_detector_assert.svh
// Assertion macros for the MACD divergence detector.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef MACD_DIVERGENCE_DETECTOR_ASSERT_SVH
`define MACD_DIVERGENCE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MACD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MACD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/macd_pkg.sv
// Shared types and constants for the MACD divergence detector.
// No dependencies; used by macd_ring_mem and macd_divergence_detector.
`timescale 1ns / 1ps

package macd_pkg;

  localparam int MAX_WINDOW_DEF = 32;

  localparam int PRICE_W    = 32;
  localparam int IN_DATA_W  = 5 * PRICE_W;
  localparam int OUT_DATA_W = 8;

  // configuration port
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UTURN_LEN  = 1'd1;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 6'd26;
  localparam logic [CFG_W-1:0] UTURN_LEN_RST  = 6'd11;

  // divergence codes
  localparam int DIV_W = 3;
  localparam logic [DIV_W-1:0] DIV_NORMAL     = 3'd0;
  localparam logic [DIV_W-1:0] DIV_TOP        = 3'd1;
  localparam logic [DIV_W-1:0] DIV_BOTTOM     = 3'd2;
  localparam logic [DIV_W-1:0] DIV_TOP_SUB    = 3'd3;
  localparam logic [DIV_W-1:0] DIV_BOTTOM_SUB = 3'd4;

  // one stored bar
  typedef struct packed {
    logic signed [PRICE_W-1:0] dif;
    logic [PRICE_W-1:0]        body_low;
    logic [PRICE_W-1:0]        body_high;
    logic [PRICE_W-1:0]        bar_low;
    logic [PRICE_W-1:0]        bar_high;
  } bar_entry_t;

endpackage

>>> sv/macd_ring_mem.sv
// Ring store of past bars: one write port, one read port with registered data.
// Depends on macd_pkg for the bar entry type.
`timescale 1ns / 1ps

module macd_ring_mem #(
  parameter int DEPTH  = macd_pkg::MAX_WINDOW_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  macd_pkg::bar_entry_t wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output macd_pkg::bar_entry_t rd_data
);

  macd_pkg::bar_entry_t mem [DEPTH];
  macd_pkg::bar_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/macd_divergence_detector.sv
// Top level of the MACD divergence detector: sequencer, window scan and result register.
// Depends on macd_pkg, macd_ring_mem and macd_divergence_detector_assert.svh.
//
// Usage:
//  - in_* carries one price bar per transfer (open, high, low, close, MACD dif).
//  - out_* carries one result per bar: divergence type and the U-turn flag.
//  - cfg_* writes window_len (index 0) or uturn_len (index 1); always ready.
//    Write only while the block is idle.
//  - Once window_len bars are stored, a bar is scanned against the window_len
//    bars before it, one ring store entry per cycle through its single read port.
//    A bar passes through the scan, drain and final steps before its result is
//    registered; during warm-up it goes straight to the final step.
//  - One bar is in flight at a time: in_tready is high only when the sequencer
//    is idle, so a new bar is taken only once the last one has left its final step.
//  - The result sits in an output register; the next bar may be taken while it
//    waits. If out_tready stays low, the following bar holds at its final step.
//  - Reset clears the ring position, the bar count and the registers to
//    window_len 26, uturn_len 11. Store contents are not cleared; warm-up
//    ensures only written entries are read.
`timescale 1ns / 1ps
`include "macd_divergence_detector_assert.svh"

module macd_divergence_detector #(
  parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // bar input: open, high, low, close, dif (32 bits each, open lowest)
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [macd_pkg::IN_DATA_W-1:0]     in_tdata,
  // result: div_type [2:0], u_turn [3], zero fill [7:4]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [macd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [macd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [macd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W  = (CNT_W > macd_pkg::CFG_W) ? CNT_W : macd_pkg::CFG_W;
  localparam int PW     = macd_pkg::PRICE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [macd_pkg::CFG_W-1:0] window_len_r, uturn_len_r;
  logic [SLOT_W-1:0]          wr_slot_r;
  logic [CNT_W-1:0]           bars_seen_r;

  // current bar
  logic [PW-1:0]        hi_r, lo_r, bh_r, bl_r;
  logic signed [PW-1:0] dif_r;
  logic [CNT_W-1:0]     w_r, u_r;
  logic                 warm_r;

  // scan control
  logic [CNT_W-1:0] iss_k_r;
  logic             rd_vld_r;
  logic [CNT_W-1:0] rd_k_r;

  // window extremes
  logic [PW-1:0]        bar_hi_max_r, bar_lo_min_r, body_hi_max_r, body_lo_min_r;
  logic signed [PW-1:0] dif_max_r, dif_min_r, umax_r, umin_r;
  logic [CNT_W-1:0]     umax_k_r, umin_k_r;

  // result register
  logic                         out_tvalid_r;
  logic [macd_pkg::DIV_W-1:0]   out_div_r;
  logic                         out_ut_r;

  logic in_fire, fin_fire;
  logic [macd_pkg::DIV_W-1:0] div_c;
  logic                       ut_c, top_side;
  logic main_top, main_bot, sub_top, sub_bot;

  logic [EXT_W-1:0] win_ext, uturn_ext;
  logic [CNT_W-1:0] w_eff, u_eff;

  logic [SLOT_W-1:0]     rd_addr;
  logic [CNT_W:0]        addr_sum;
  macd_pkg::bar_entry_t  rd_entry, wr_entry;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin_fire  = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= macd_pkg::WINDOW_LEN_RST;
      uturn_len_r  <= macd_pkg::UTURN_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        macd_pkg::CFG_WINDOW_LEN: window_len_r <= cfg_data;
        macd_pkg::CFG_UTURN_LEN:  uturn_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp window to [2, MAX_WINDOW] and U-turn span to [2, window]
  always_comb begin
    win_ext = EXT_W'(window_len_r);
    if (win_ext < EXT_W'(2)) win_ext = EXT_W'(2);
    if (win_ext > EXT_W'(MAX_WINDOW)) win_ext = EXT_W'(MAX_WINDOW);
    uturn_ext = EXT_W'(uturn_len_r);
    if (uturn_ext < EXT_W'(2)) uturn_ext = EXT_W'(2);
    if (uturn_ext > win_ext) uturn_ext = win_ext;
    w_eff = CNT_W'(win_ext);
    u_eff = CNT_W'(uturn_ext);
  end

  // ring slot of the bar k back from the write position
  always_comb begin
    if (iss_k_r > CNT_W'(wr_slot_r)) begin
      addr_sum = (CNT_W+1)'(wr_slot_r) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(iss_k_r);
    end else begin
      addr_sum = (CNT_W+1)'(wr_slot_r) - (CNT_W+1)'(iss_k_r);
    end
    rd_addr = SLOT_W'(addr_sum);
  end

  assign wr_entry.dif       = dif_r;
  assign wr_entry.body_low  = bl_r;
  assign wr_entry.body_high = bh_r;
  assign wr_entry.bar_low   = lo_r;
  assign wr_entry.bar_high  = hi_r;

  macd_ring_mem #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fin_fire),
    .wr_addr (wr_slot_r),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = (bars_seen_r < w_eff) ? S_FIN : S_SCAN;
      S_SCAN:  if (iss_k_r == CNT_W'(1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_slot_r   <= '0;
      bars_seen_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);
      if (fin_fire) begin
        wr_slot_r <= (wr_slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : wr_slot_r + SLOT_W'(1);
        if (bars_seen_r < CNT_W'(MAX_WINDOW)) bars_seen_r <= bars_seen_r + CNT_W'(1);
      end
    end
  end

  // latch the bar and issue reads oldest first
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hi_r    <= in_tdata[2*PW-1:PW];
      lo_r    <= in_tdata[3*PW-1:2*PW];
      bh_r    <= (in_tdata[PW-1:0] > in_tdata[4*PW-1:3*PW]) ?
                 in_tdata[PW-1:0] : in_tdata[4*PW-1:3*PW];
      bl_r    <= (in_tdata[PW-1:0] < in_tdata[4*PW-1:3*PW]) ?
                 in_tdata[PW-1:0] : in_tdata[4*PW-1:3*PW];
      dif_r   <= in_tdata[5*PW-1:4*PW];
      w_r     <= w_eff;
      u_r     <= u_eff;
      warm_r  <= (bars_seen_r < w_eff);
      iss_k_r <= w_eff;
    end else if (state_r == S_SCAN) begin
      iss_k_r <= iss_k_r - CNT_W'(1);
    end
    if (state_r == S_SCAN) begin
      rd_k_r <= iss_k_r;
    end
  end

  // window extremes, one entry per cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bar_hi_max_r  <= '0;
      bar_lo_min_r  <= '1;
      body_hi_max_r <= '0;
      body_lo_min_r <= '1;
      dif_max_r     <= {1'b1, {(PW-1){1'b0}}};
      dif_min_r     <= {1'b0, {(PW-1){1'b1}}};
    end else if (rd_vld_r) begin
      if (rd_entry.bar_high > bar_hi_max_r)   bar_hi_max_r  <= rd_entry.bar_high;
      if (rd_entry.bar_low < bar_lo_min_r)    bar_lo_min_r  <= rd_entry.bar_low;
      if (rd_entry.body_high > body_hi_max_r) body_hi_max_r <= rd_entry.body_high;
      if (rd_entry.body_low < body_lo_min_r)  body_lo_min_r <= rd_entry.body_low;
      if (rd_entry.dif > dif_max_r)           dif_max_r     <= rd_entry.dif;
      if (rd_entry.dif < dif_min_r)           dif_min_r     <= rd_entry.dif;
      // U-turn span: first entry seeds, later ones replace on strict compare
      if (rd_k_r == u_r - CNT_W'(1)) begin
        umax_r   <= rd_entry.dif;
        umax_k_r <= rd_k_r;
        umin_r   <= rd_entry.dif;
        umin_k_r <= rd_k_r;
      end else if (rd_k_r < u_r - CNT_W'(1)) begin
        if (rd_entry.dif > umax_r) begin
          umax_r   <= rd_entry.dif;
          umax_k_r <= rd_k_r;
        end
        if (rd_entry.dif < umin_r) begin
          umin_r   <= rd_entry.dif;
          umin_k_r <= rd_k_r;
        end
      end
    end
  end

  // final decision; main test before sub, top before bottom
  assign main_top = (bar_hi_max_r < hi_r) && (dif_max_r > dif_r);
  assign main_bot = (bar_lo_min_r > lo_r) && (dif_min_r < dif_r);
  assign sub_top  = (body_hi_max_r < hi_r) && (dif_max_r > dif_r);
  assign sub_bot  = (body_lo_min_r > lo_r) && (dif_min_r < dif_r);

  always_comb begin
    priority if (warm_r)   div_c = macd_pkg::DIV_NORMAL;
    else if (main_top)     div_c = macd_pkg::DIV_TOP;
    else if (main_bot)     div_c = macd_pkg::DIV_BOTTOM;
    else if (sub_top)      div_c = macd_pkg::DIV_TOP_SUB;
    else if (sub_bot)      div_c = macd_pkg::DIV_BOTTOM_SUB;
    else                   div_c = macd_pkg::DIV_NORMAL;
  end

  assign top_side = (div_c == macd_pkg::DIV_TOP) || (div_c == macd_pkg::DIV_TOP_SUB);

  // current bar only wins the extreme on a strict compare
  always_comb begin
    if (div_c == macd_pkg::DIV_NORMAL) begin
      ut_c = 1'b0;
    end else if (top_side) begin
      ut_c = !(dif_r > umax_r) && (umax_k_r == CNT_W'(1));
    end else begin
      ut_c = !(dif_r < umin_r) && (umin_k_r == CNT_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_div_r <= div_c;
      out_ut_r  <= ut_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(macd_pkg::OUT_DATA_W - macd_pkg::DIV_W - 1){1'b0}},
                       out_ut_r, out_div_r};

  // checks
  `MACD_ASSERT_NEXT(a_warm_normal, fin_fire && warm_r,
    out_div_r == macd_pkg::DIV_NORMAL, "result during warm-up is not normal")
  `MACD_ASSERT_NOW(a_uturn_needs_div, out_tvalid_r && out_div_r == macd_pkg::DIV_NORMAL,
    !out_ut_r, "U-turn flag set without a divergence")
  `MACD_ASSERT_NOW(a_bars_sat, 1'b1, bars_seen_r <= CNT_W'(MAX_WINDOW),
    "bar count beyond store depth")
  `MACD_ASSERT_NOW(a_scan_range, state_r == S_SCAN,
    iss_k_r != '0 && iss_k_r <= w_r, "scan position outside the window")

endmodule
